### sv/tfrs_pkg.sv
package tfrs_pkg;

	localparam int unsigned SCREEN_W = 320;
	localparam int unsigned SCREEN_H = 240;
	localparam int unsigned TILE_MIN = 64;
	localparam int unsigned TILE_MAX = 256;

	localparam logic REG_TILE_WIDTH  = 1'b0;
	localparam logic REG_TILE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic start;
		logic emit;
	} tfrs_cmd_t;

	typedef struct packed {
		logic empty;
		logic mod_done;
		logic piece_last;
	} tfrs_stat_t;

	function automatic logic [8:0] clamp_tile(input logic [8:0] v);
		logic [8:0] r;
		r = v;
		if (v < 9'(TILE_MIN))
			r = 9'(TILE_MIN);
		else if (v > 9'(TILE_MAX))
			r = 9'(TILE_MAX);
		return r;
	endfunction

endpackage

### sv/tfrs_ctrl.sv
module tfrs_ctrl
	import tfrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  tfrs_stat_t stat,
	output tfrs_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!stat.empty)
						state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (stat.mod_done) begin
					cmd.start = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					if (stat.piece_last)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/tfrs_dp.sv
module tfrs_dp
	import tfrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [8:0] wr_data,
	input  logic [8:0] rect_x,
	input  logic [7:0] rect_y,
	input  logic [8:0] rect_w,
	input  logic [7:0] rect_h,
	input  tfrs_cmd_t  cmd,
	output tfrs_stat_t stat,
	output logic [9:0] dest_x,
	output logic [8:0] dest_y,
	output logic [8:0] piece_w,
	output logic [8:0] piece_h,
	output logic [7:0] src_x,
	output logic [7:0] src_y,
	output logic       last_piece
);

	logic [8:0] tile_w_q, tile_h_q;
	logic [8:0] tw, th;

	logic [8:0] rx_q, rw_q, rem_x_q, rem_y_q, left_w_q;
	logic [7:0] rh_q, left_h_q, off_x_q, off_y_q;
	logic [9:0] cur_x_q;
	logic [8:0] cur_y_q;

	logic [8:0] pw_full, ph_full, pw, ph;
	logic       row_end, last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w_q <= 9'(TILE_MIN);
			tile_h_q <= 9'(TILE_MIN);
		end else if (wr_en) begin
			case (wr_index)
				REG_TILE_WIDTH:  tile_w_q <= wr_data;
				REG_TILE_HEIGHT: tile_h_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign tw = clamp_tile(tile_w_q);
	assign th = clamp_tile(tile_h_q);

	assign pw_full = tw - {1'b0, off_x_q};
	assign ph_full = th - {1'b0, off_y_q};
	assign pw      = (pw_full > left_w_q) ? left_w_q : pw_full;
	assign ph      = (ph_full > {1'b0, left_h_q}) ? {1'b0, left_h_q} : ph_full;
	assign row_end = (pw == left_w_q);
	assign last    = row_end && (ph == {1'b0, left_h_q});

	assign stat.empty      = (rect_w == '0) || (rect_h == '0);
	assign stat.mod_done   = (rem_x_q < tw) && (rem_y_q < th);
	assign stat.piece_last = last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rx_q    <= rect_x;
			rw_q    <= (rect_w > 9'(SCREEN_W)) ? 9'(SCREEN_W) : rect_w;
			rh_q    <= (rect_h > 8'(SCREEN_H)) ? 8'(SCREEN_H) : rect_h;
			rem_x_q <= rect_x;
			rem_y_q <= {1'b0, rect_y};
			cur_y_q <= {1'b0, rect_y};
		end
		if (cmd.mod_step) begin
			if (rem_x_q >= tw)
				rem_x_q <= rem_x_q - tw;
			if (rem_y_q >= th)
				rem_y_q <= rem_y_q - th;
		end
		if (cmd.start) begin
			off_y_q  <= rem_y_q[7:0];
			left_h_q <= rh_q;
			cur_x_q  <= {1'b0, rx_q};
			left_w_q <= rw_q;
			off_x_q  <= rem_x_q[7:0];
		end
		if (cmd.emit) begin
			dest_x     <= cur_x_q;
			dest_y     <= cur_y_q;
			piece_w    <= pw;
			piece_h    <= ph;
			src_x      <= off_x_q;
			src_y      <= off_y_q;
			last_piece <= last;
			if (row_end) begin
				cur_y_q  <= cur_y_q + ph;
				left_h_q <= left_h_q - ph[7:0];
				off_y_q  <= '0;
				cur_x_q  <= {1'b0, rx_q};
				left_w_q <= rw_q;
				off_x_q  <= rem_x_q[7:0];
			end else begin
				cur_x_q  <= cur_x_q + {1'b0, pw};
				left_w_q <= left_w_q - pw;
				off_x_q  <= '0;
			end
		end
	end

endmodule

### sv/tile_fill_rect_splitter.sv
// channel   handshake              payload
// config    wr_en                  wr_index, wr_data
// in        in_valid / in_ready    rect_x, rect_y, rect_w, rect_h
// out       out_valid / out_ready  dest_x, dest_y, piece_w, piece_h, src_x, src_y, last_piece
//
// an item is taken, then repeated subtraction finds the two tile offsets, the first row is
// loaded, and the pieces follow (up to 30), each when the output register is free
// a new item is taken only once the previous item's last piece is in the output register
// out_ready low holds the piece sequence; the registered output parts the two sides
// reset sets both tile sizes to 64 and empties the output register
module tile_fill_rect_splitter
	import tfrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [8:0] wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [8:0] rect_x,
	input  logic [7:0] rect_y,
	input  logic [8:0] rect_w,
	input  logic [7:0] rect_h,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] dest_x,
	output logic [8:0] dest_y,
	output logic [8:0] piece_w,
	output logic [8:0] piece_h,
	output logic [7:0] src_x,
	output logic [7:0] src_y,
	output logic       last_piece
);

	tfrs_cmd_t  cmd;
	tfrs_stat_t stat;

	tfrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tfrs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.cmd        (cmd),
		.stat       (stat),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.piece_w    (piece_w),
		.piece_h    (piece_h),
		.src_x      (src_x),
		.src_y      (src_y),
		.last_piece (last_piece)
	);

endmodule

### bench/tb_tile_fill_rect_splitter.sv
module tb_tile_fill_rect_splitter
	import tfrs_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [9:0] dx;
		logic [8:0] dy;
		logic [8:0] w;
		logic [8:0] h;
		logic [7:0] sx;
		logic [7:0] sy;
		logic       last;
	} piece_t;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_ONE_PIECE,
		ROW_NO_PIECE
	} row_kind_t;

	typedef struct packed {
		logic [8:0] x;
		logic [7:0] y;
		logic [8:0] w;
		logic [7:0] h;
		row_kind_t  kind;
		piece_t     want;
	} rect_row_t;

	localparam int NUM_ROWS = 14;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 52;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       wr_en = 1'b0;
	logic       wr_index = 1'b0;
	logic [8:0] wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [8:0] rect_x = '0;
	logic [7:0] rect_y = '0;
	logic [8:0] rect_w = '0;
	logic [7:0] rect_h = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [9:0] dest_x;
	logic [8:0] dest_y;
	logic [8:0] piece_w;
	logic [8:0] piece_h;
	logic [7:0] src_x;
	logic [7:0] src_y;
	logic       last_piece;

	piece_t     pending_pieces[$];
	logic [8:0] tile_w_cfg = 9'd64;
	logic [8:0] tile_h_cfg = 9'd64;
	int         mismatches = 0;
	int         pieces_seen = 0;
	int         in_idle_pct = 8;
	int         out_idle_pct = 59;
	bit         held_off = 1'b0;

	tile_fill_rect_splitter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.piece_w    (piece_w),
		.piece_h    (piece_h),
		.src_x      (src_x),
		.src_y      (src_y),
		.last_piece (last_piece)
	);

	always #5 clk = ~clk;

	function automatic int unsigned tile_size(input logic [8:0] v);
		if (v < 9'(TILE_MIN))
			return TILE_MIN;
		if (v > 9'(TILE_MAX))
			return TILE_MAX;
		return int'(v);
	endfunction

	// breaks one rectangle into blitter pieces, row-major
	task automatic split_rect(input logic [8:0] x, input logic [7:0] y,
			input logic [8:0] w, input logic [7:0] h);
		int unsigned tw, th, rw, rh, left_h, left_w, cur_x, cur_y, off_x, off_y, pw, ph;
		int          n;
		piece_t      p;
		tw = tile_size(tile_w_cfg);
		th = tile_size(tile_h_cfg);
		rw = (w > 9'(SCREEN_W)) ? SCREEN_W : int'(w);
		rh = (h > 8'(SCREEN_H)) ? SCREEN_H : int'(h);
		n = 0;
		if (rw == 0 || rh == 0)
			return;
		left_h = rh;
		cur_y = y;
		off_y = y % th;
		while (left_h > 0 && n < 30) begin
			ph = th - off_y;
			if (ph > left_h)
				ph = left_h;
			left_w = rw;
			cur_x = x;
			off_x = x % tw;
			while (left_w > 0 && n < 30) begin
				pw = tw - off_x;
				if (pw > left_w)
					pw = left_w;
				p.dx = 10'(cur_x);
				p.dy = 9'(cur_y);
				p.w = 9'(pw);
				p.h = 9'(ph);
				p.sx = 8'(off_x);
				p.sy = 8'(off_y);
				p.last = (left_w == pw && left_h == ph);
				pending_pieces.push_back(p);
				n++;
				cur_x += pw;
				left_w -= pw;
				off_x = 0;
			end
			cur_y += ph;
			left_h -= ph;
			off_y = 0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("piece %0d %s got %0d want %0d",
				pieces_seen, name, got, want));
	endtask

	task automatic write_reg(input logic idx, input logic [8:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		if (idx == REG_TILE_WIDTH)
			tile_w_cfg = data;
		else
			tile_h_cfg = data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// called at a rising edge, returns at the edge that takes the item
	task automatic send_rect(input logic [8:0] x, input logic [7:0] y,
			input logic [8:0] w, input logic [7:0] h);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rect_x <= x;
		rect_y <= y;
		rect_w <= w;
		rect_h <= h;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		@(posedge clk);
		while (pending_pieces.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver side: random stalls, one long hold-off, field checks
	initial begin
		piece_t want;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && pieces_seen >= 150) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= out_idle_pct);
			@(negedge clk);
			if (out_valid && out_ready) begin
				if (pending_pieces.size() == 0) begin
					report_mismatch($sformatf("unexpected piece at %0d,%0d",
						dest_x, dest_y));
				end else begin
					want = pending_pieces.pop_front();
					check_field("dest_x", dest_x, want.dx);
					check_field("dest_y", dest_y, want.dy);
					check_field("piece_w", piece_w, want.w);
					check_field("piece_h", piece_h, want.h);
					check_field("src_x", src_x, want.sx);
					check_field("src_y", src_y, want.sy);
					check_field("last_piece", last_piece, want.last);
				end
				pieces_seen++;
			end
		end
	end

	initial begin
		rect_row_t  directed_rows [0:NUM_ROWS-1];
		logic [8:0] tw_set [0:NUM_PHASES-1];
		logic [8:0] th_set [0:NUM_PHASES-1];
		rect_row_t  row;
		logic [8:0] x, w;
		logic [7:0] y, h;

		directed_rows = '{
			'{9'd0,   8'd0,   9'd1,   8'd1,   ROW_ONE_PIECE,
				'{10'd0, 9'd0, 9'd1, 9'd1, 8'd0, 8'd0, 1'b1}},
			'{9'd0,   8'd0,   9'd0,   8'd5,   ROW_NO_PIECE, '0},
			'{9'd0,   8'd0,   9'd5,   8'd0,   ROW_NO_PIECE, '0},
			'{9'd0,   8'd0,   9'd0,   8'd0,   ROW_NO_PIECE, '0},
			'{9'd0,   8'd0,   9'd64,  8'd64,  ROW_ONE_PIECE,
				'{10'd0, 9'd0, 9'd64, 9'd64, 8'd0, 8'd0, 1'b1}},
			'{9'd63,  8'd63,  9'd1,   8'd1,   ROW_ONE_PIECE,
				'{10'd63, 9'd63, 9'd1, 9'd1, 8'd63, 8'd63, 1'b1}},
			'{9'd319, 8'd239, 9'd1,   8'd1,   ROW_ONE_PIECE,
				'{10'd319, 9'd239, 9'd1, 9'd1, 8'd63, 8'd47, 1'b1}},
			'{9'd319, 8'd239, 9'd320, 8'd240, ROW_PREDICT, '0},
			'{9'd511, 8'd255, 9'd511, 8'd255, ROW_PREDICT, '0},
			'{9'd0,   8'd0,   9'd320, 8'd240, ROW_PREDICT, '0},
			'{9'd1,   8'd1,   9'd320, 8'd240, ROW_PREDICT, '0},
			'{9'd256, 8'd128, 9'd300, 8'd200, ROW_PREDICT, '0},
			'{9'd0,   8'd0,   9'd320, 8'd1,   ROW_PREDICT, '0},
			'{9'd0,   8'd0,   9'd1,   8'd240, ROW_PREDICT, '0}
		};
		tw_set = '{9'd0, 9'd511, 9'd63, 9'd256, 9'd100, 9'd257, 9'd64, 9'd0};
		th_set = '{9'd511, 9'd0, 9'd257, 9'd64, 9'd200, 9'd63, 9'd64, 9'd0};
		tw_set[7] = 9'($urandom_range(64, 256));
		th_set[7] = 9'($urandom_range(64, 256));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_ONE_PIECE: pending_pieces.push_back(row.want);
				ROW_PREDICT:   split_rect(row.x, row.y, row.w, row.h);
				default: ;
			endcase
			send_rect(row.x, row.y, row.w, row.h);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			in_valid <= 1'b0;
			wait_drained();
			if (ph < 3) begin
				in_idle_pct = 8;
				out_idle_pct = 59;
			end else if (ph < 6) begin
				in_idle_pct = 59;
				out_idle_pct = 8;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			write_reg(REG_TILE_WIDTH, tw_set[ph]);
			write_reg(REG_TILE_HEIGHT, th_set[ph]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				case ($urandom_range(9))
					0: begin
						x = 9'($urandom_range(319));
						y = 8'($urandom_range(239));
						w = 9'($urandom_range(1, 8));
						h = 8'($urandom_range(1, 8));
					end
					1: begin
						x = 9'($urandom);
						y = 8'($urandom);
						w = 9'($urandom);
						h = 8'($urandom);
					end
					2: begin
						x = 9'($urandom_range(319));
						y = 8'($urandom_range(239));
						w = $urandom_range(1) ? 9'd0 : 9'($urandom_range(1, 320));
						h = (w != 0) ? 8'd0 : 8'($urandom);
					end
					default: begin
						x = 9'($urandom_range(319));
						y = 8'($urandom_range(239));
						w = 9'($urandom_range(1, 320));
						h = 8'($urandom_range(1, 240));
					end
				endcase
				split_rect(x, y, w, h);
				send_rect(x, y, w, h);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		if (pending_pieces.size() != 0)
			report_mismatch($sformatf("%0d pieces never arrived", pending_pieces.size()));
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
sv/tfrs_pkg.sv
sv/tfrs_ctrl.sv
sv/tfrs_dp.sv
sv/tile_fill_rect_splitter.sv
bench/tb_tile_fill_rect_splitter.sv
